// ===== hdl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants shared by the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int CB = 16;
   localparam int FB = 16;

   typedef struct packed {
      logic signed [CB-1:0] p_start_x;
      logic signed [CB-1:0] p_start_y;
      logic signed [CB-1:0] p_end_x;
      logic signed [CB-1:0] p_end_y;
      logic signed [CB-1:0] q_start_x;
      logic signed [CB-1:0] q_start_y;
      logic signed [CB-1:0] q_end_x;
      logic signed [CB-1:0] q_end_y;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic                 degenerate;
      logic [FB:0]          alpha_p;
      logic [FB:0]          alpha_q;
      logic signed [CB-1:0] cross_x;
      logic signed [CB-1:0] cross_y;
   } rsp_type;

endpackage

// ===== hdl/sit_div.sv =====
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring fraction divider: q = floor(n * 2^F / d), one bit per
// stage, for 0 < n < d. Stalls with the enclosing pipeline.
// ----------------------------------------------------------------------------
module sit_div
   import sit_pkg::*;
#(
   parameter int NB = 34,
   parameter int F  = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NB-1:0] n,
   input  logic [NB-1:0] d,
   output logic [F-1:0]  q
);

   logic [NB:0]   r_ff [F];
   logic [NB-1:0] d_ff [F];
   logic [F-1:0]  q_ff [F];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < F; i++) begin
            logic [NB+1:0] t;
            logic [NB:0]   rp;
            logic [NB-1:0] dp;
            logic [F-1:0]  qp;
            rp = (i == 0) ? {1'b0, n} : r_ff[i-1];
            dp = (i == 0) ? d : d_ff[i-1];
            qp = (i == 0) ? '0 : q_ff[i-1];
            t  = {rp, 1'b0};
            if (t >= {2'b00, dp}) begin
               r_ff[i] <= (NB+1)'(t - {2'b00, dp});
               q_ff[i] <= {qp[F-2:0], 1'b1};
            end else begin
               r_ff[i] <= (NB+1)'(t);
               q_ff[i] <= {qp[F-2:0], 1'b0};
            end
            d_ff[i] <= dp;
         end
      end
   end

   assign q = q_ff[F-1];

endmodule

// ===== hdl/sit_front.sv =====
// ----------------------------------------------------------------------------
// sit_front
// Box rejection and the four cross products, two register stages.
// ----------------------------------------------------------------------------
module sit_front
   import sit_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  req_type                      req,
   output logic                         hit,
   output logic                         degen,
   output logic [2*COORD_BITS+1:0]      mp1,
   output logic [2*COORD_BITS+1:0]      mp2,
   output logic [2*COORD_BITS+1:0]      mq1,
   output logic [2*COORD_BITS+1:0]      mq2,
   output logic signed [COORD_BITS-1:0] qx,
   output logic signed [COORD_BITS-1:0] qy,
   output logic signed [COORD_BITS:0]   dx,
   output logic signed [COORD_BITS:0]   dy
);

   localparam int C = COORD_BITS;
   localparam int W = 2*C + 3;

   logic signed [C-1:0] px1, py1, px2, py2, qx1, qy1, qx2, qy2;
   assign px1 = req.p_start_x[C-1:0];
   assign py1 = req.p_start_y[C-1:0];
   assign px2 = req.p_end_x[C-1:0];
   assign py2 = req.p_end_y[C-1:0];
   assign qx1 = req.q_start_x[C-1:0];
   assign qy1 = req.q_start_y[C-1:0];
   assign qx2 = req.q_end_x[C-1:0];
   assign qy2 = req.q_end_y[C-1:0];

   // stage 1: outcode reject and the eight products
   logic                  rej;
   logic signed [C-1:0]   bx0, bx1, by0, by1;
   logic [3:0]            oc1, oc2;
   logic signed [C:0]     a1, a2, b1, b2, qdy, qdx, c1, c2, e1, e2, pdy, pdx;
   always_comb begin
      bx0 = (qx1 < qx2) ? qx1 : qx2;
      bx1 = (qx1 < qx2) ? qx2 : qx1;
      by0 = (qy1 < qy2) ? qy1 : qy2;
      by1 = (qy1 < qy2) ? qy2 : qy1;
      oc1 = {px1 < bx0, px1 > bx1, py1 < by0, py1 > by1};
      oc2 = {px2 < bx0, px2 > bx1, py2 < by0, py2 > by1};
      rej = |(oc1 & oc2);
      a1  = (C+1)'(px1) - (C+1)'(qx1);
      a2  = (C+1)'(px2) - (C+1)'(qx1);
      b1  = (C+1)'(py1) - (C+1)'(qy1);
      b2  = (C+1)'(py2) - (C+1)'(qy1);
      qdy = (C+1)'(qy1) - (C+1)'(qy2);
      qdx = (C+1)'(qx2) - (C+1)'(qx1);
      c1  = (C+1)'(qx1) - (C+1)'(px1);
      c2  = (C+1)'(qx2) - (C+1)'(px1);
      e1  = (C+1)'(qy1) - (C+1)'(py1);
      e2  = (C+1)'(qy2) - (C+1)'(py1);
      pdy = (C+1)'(py1) - (C+1)'(py2);
      pdx = (C+1)'(px2) - (C+1)'(px1);
   end

   logic                      rej_ff;
   logic signed [2*C+1:0]     pr_ff [8];
   logic signed [C-1:0]       qx_ff, qy_ff;
   logic signed [C:0]         dx_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rej_ff   <= rej;
         pr_ff[0] <= a1 * qdy;
         pr_ff[1] <= b1 * qdx;
         pr_ff[2] <= a2 * qdy;
         pr_ff[3] <= b2 * qdx;
         pr_ff[4] <= c1 * pdy;
         pr_ff[5] <= e1 * pdx;
         pr_ff[6] <= c2 * pdy;
         pr_ff[7] <= e2 * pdx;
         qx_ff    <= qx1;
         qy_ff    <= qy1;
         dx_ff    <= qdx;
         dy_ff    <= -qdy;
      end
   end

   // stage 2: sums, side tests, magnitudes
   logic signed [W-1:0] wp1, wp2, wq1, wq2;
   logic                sp, sq, z;
   always_comb begin
      wp1 = W'(pr_ff[0]) + W'(pr_ff[1]);
      wp2 = W'(pr_ff[2]) + W'(pr_ff[3]);
      wq1 = W'(pr_ff[4]) + W'(pr_ff[5]);
      wq2 = W'(pr_ff[6]) + W'(pr_ff[7]);
      z   = (wp1 == 0) || (wp2 == 0) || (wq1 == 0) || (wq2 == 0);
      sp  = (wp1 == 0) || (wp2 == 0) || (wp1[W-1] != wp2[W-1]);
      sq  = (wq1 == 0) || (wq2 == 0) || (wq1[W-1] != wq2[W-1]);
   end

   logic              hit_ff, deg_ff;
   logic [W-2:0]      m_ff [4];
   logic signed [C-1:0] qx2_ff, qy2_ff;
   logic signed [C:0]   dx2_ff, dy2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= !rej_ff && sp && sq;
         deg_ff <= !rej_ff && sp && sq && z;
         m_ff[0] <= (W-1)'(wp1[W-1] ? -wp1 : wp1);
         m_ff[1] <= (W-1)'(wp2[W-1] ? -wp2 : wp2);
         m_ff[2] <= (W-1)'(wq1[W-1] ? -wq1 : wq1);
         m_ff[3] <= (W-1)'(wq2[W-1] ? -wq2 : wq2);
         qx2_ff <= qx_ff;
         qy2_ff <= qy_ff;
         dx2_ff <= dx_ff;
         dy2_ff <= dy_ff;
      end
   end

   assign hit   = hit_ff;
   assign degen = deg_ff;
   assign mp1   = m_ff[0];
   assign mp2   = m_ff[1];
   assign mq1   = m_ff[2];
   assign mq2   = m_ff[3];
   assign qx    = qx2_ff;
   assign qy    = qy2_ff;
   assign dx    = dx2_ff;
   assign dy    = dy2_ff;

endmodule

// ===== hdl/segment_intersection_test_core.sv =====
// Path: front stages, divider chain, lerp stage, output and skid registers.
// Throughput: one item per cycle; set by the fully pipelined divider chain.
// The pipeline stalls only while the output register holds an item that is
// not taken; req_ready follows rsp_ready combinationally.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Segment pair intersection: box reject, side tests, alphas, crossing point.
// ----------------------------------------------------------------------------
module segment_intersection_test_core
   import sit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int C  = CB;
   localparam int F  = FB;
   localparam int MW = 2*C + 2;
   localparam int NB = MW + 1;
   localparam int L  = F + 4;

   logic en;
   logic [L-1:0] vld_ff;
   logic out_free;
   logic skid_v_ff;
   rsp_type skid_ff;

   // pipeline advances unless the last stage and the skid both hold items and rsp_ready is low
   assign out_free  = !vld_ff[L-1] || !skid_v_ff || rsp_ready;
   assign en        = out_free;
   assign req_ready = en;

   logic hit, degen;
   logic [MW-1:0] mp1, mp2, mq1, mq2;
   logic signed [C-1:0] qx, qy;
   logic signed [C:0] dx, dy;

   sit_front #(.COORD_BITS(C)) u_front (
      .clock(clock), .en(en), .req(req_data), .hit(hit), .degen(degen),
      .mp1(mp1), .mp2(mp2), .mq1(mq1), .mq2(mq2),
      .qx(qx), .qy(qy), .dx(dx), .dy(dy)
   );

   logic [F-1:0] ap, aq;
   sit_div #(.NB(NB), .F(F)) u_div_p (
      .clock(clock), .en(en), .n({1'b0, mp1}),
      .d(NB'({1'b0, mp1}) + NB'({1'b0, mp2})), .q(ap)
   );
   sit_div #(.NB(NB), .F(F)) u_div_q (
      .clock(clock), .en(en), .n({1'b0, mq1}),
      .d(NB'({1'b0, mq1}) + NB'({1'b0, mq2})), .q(aq)
   );

   // side info delayed along the divider
   logic [1:0]          fl_ff [F];
   logic signed [C-1:0] qx_ff [F], qy_ff [F];
   logic signed [C:0]   dx_ff [F], dy_ff [F];
   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= {hit, degen};
         qx_ff[0] <= qx;
         qy_ff[0] <= qy;
         dx_ff[0] <= dx;
         dy_ff[0] <= dy;
         for (int i = 1; i < F; i++) begin
            fl_ff[i] <= fl_ff[i-1];
            qx_ff[i] <= qx_ff[i-1];
            qy_ff[i] <= qy_ff[i-1];
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
         end
      end
   end

   // lerp: multiply stage, then floor shift and add
   logic [1:0]             f2_ff;
   logic [F-1:0]           ap_ff, aq_ff;
   logic signed [C+F+1:0]  px_ff, py_ff;
   logic signed [C-1:0]    bx_ff, by_ff;
   logic clean;
   assign clean = fl_ff[F-1][1] && !fl_ff[F-1][0];

   always_ff @(posedge clock) begin
      if (en) begin
         f2_ff <= fl_ff[F-1];
         ap_ff <= clean ? ap : '0;
         aq_ff <= clean ? aq : '0;
         px_ff <= $signed({2'b00, aq}) * dx_ff[F-1];
         py_ff <= $signed({2'b00, aq}) * dy_ff[F-1];
         bx_ff <= qx_ff[F-1];
         by_ff <= qy_ff[F-1];
      end
   end

   rsp_type res;
   logic clean2;
   assign clean2 = f2_ff[1] && !f2_ff[0];
   always_comb begin
      res.hit        = f2_ff[1];
      res.degenerate = f2_ff[0];
      res.alpha_p    = {1'b0, ap_ff};
      res.alpha_q    = {1'b0, aq_ff};
      // arithmetic shift floors toward minus infinity
      res.cross_x    = clean2 ? C'(bx_ff + C'(px_ff >>> F)) : '0;
      res.cross_y    = clean2 ? C'(by_ff + C'(py_ff >>> F)) : '0;
   end

   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (en) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= {vld_ff[L-2:0], req_valid};
         if (vld_ff[L-1] && en) skid_v_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[L-1] && en) skid_ff <= out_ff;
   end

   assign rsp_valid = skid_v_ff;
   assign rsp_data  = skid_ff;

endmodule
